// File: hdl/drt_pkg.sv
// Shared types, sizes and codes for the dirty rectangle tracker.
// No dependencies; every other file of the block imports this package.
package drt_pkg;

    localparam int MAX_REGIONS   = 16;
    localparam int BUFFER_WIDTH  = 256;
    localparam int BUFFER_HEIGHT = 384;
    localparam int HALF_HEIGHT   = BUFFER_HEIGHT / 2;

    localparam int IN_W    = 11;
    localparam int EXT_W   = IN_W + 1;
    localparam int LEFT_W  = 8;
    localparam int COORD_W = 9;
    localparam int COUNT_W = $clog2(MAX_REGIONS + 1);
    localparam int WALK_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    localparam logic [1:0] MODE_INVALIDATE = 2'd0;
    localparam logic [1:0] MODE_REQUEST    = 2'd1;
    localparam logic [1:0] MODE_SERVICE    = 2'd2;

    typedef struct packed {
        logic [LEFT_W-1:0]  left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } region_t;

    typedef struct packed {
        logic active;
        logic found;
    } probe_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        region_t  rect;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_COMMIT,
        ST_FLUSH
    } state_t;

endpackage

// File: hdl/dirty_rectangle_tracker_core.sv
// Top level of the dirty rectangle tracker: input rounding and clipping,
// sequencer, output register and the chain of region cells.
// Depends on drt_pkg and drt_cell.
//
//   channel   handshake         payload
//   -------   ---------------   ----------------------------------------------
//   command   start / busy      mode, rect_left, rect_top, rect_right, rect_bottom
//   result    strobe (1 cycle)  screen, out_left, out_top, out_right, out_bottom, last
//
// Busy: an invalidate that survives clipping holds busy while the probe token
// walks the whole chain and through the commit step after it; no new command
// is taken until then. A dropped rectangle, a request and an unused mode leave
// busy low. A service emits one result per cycle from the head of the chain,
// which shifts down as each region is finished, and holds busy until its last
// result. Reset clears the count, the pending flag and the sequencer; the
// stored regions are not cleared. Results cannot be stalled by the receiver.
module dirty_rectangle_tracker_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 mode,
    input  logic signed [drt_pkg::IN_W-1:0] rect_left,
    input  logic signed [drt_pkg::IN_W-1:0] rect_top,
    input  logic signed [drt_pkg::IN_W-1:0] rect_right,
    input  logic signed [drt_pkg::IN_W-1:0] rect_bottom,
    output logic                       strobe,
    output logic                       screen,
    output logic [7:0]                 out_left,
    output logic [7:0]                 out_top,
    output logic [8:0]                 out_right,
    output logic signed [8:0]          out_bottom,
    output logic                       last
);
    import drt_pkg::*;

    localparam region_t FULL_SCREEN = '{
        left:   '0,
        top:    '0,
        right:  COORD_W'(BUFFER_WIDTH),
        bottom: COORD_W'(BUFFER_HEIGHT)
    };

    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  pending_reg, pending_next;
    logic                  half_reg, half_next;
    logic [WALK_W-1:0]     walk_reg, walk_next;
    region_t               rect_reg, rect_next;

    logic                  strobe_reg, strobe_next;
    logic                  screen_reg, screen_next;
    logic [7:0]            left_reg, left_next;
    logic [7:0]            top_reg, top_next;
    logic [8:0]            right_reg, right_next;
    logic [8:0]            bottom_reg, bottom_next;
    logic                  last_reg, last_next;

    cell_ctrl_t            ctrl;
    probe_t                launch;
    region_t               cell_q  [MAX_REGIONS];
    probe_t                probe_q [MAX_REGIONS];
    logic [MAX_REGIONS-1:0] in_use;
    logic [MAX_REGIONS-1:0] probe_act;

    logic                  accept;
    logic signed [EXT_W-1:0] l_ext, t_ext, b_ext, r_sum, l_even, r_even;
    logic                  drop;
    region_t               clipped;
    region_t               head;
    logic [COORD_W:0]      bot_rebased;
    logic [COORD_W-1:0]    top_rebased;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign head   = cell_q[0];

    // Round the left and right edges to even, drop off-screen rectangles, clip the rest.
    always_comb
    begin
        l_ext  = {rect_left[IN_W-1], rect_left};
        t_ext  = {rect_top[IN_W-1], rect_top};
        b_ext  = {rect_bottom[IN_W-1], rect_bottom};
        r_sum  = {rect_right[IN_W-1], rect_right} + EXT_W'(1);
        l_even = {l_ext[EXT_W-1:1], 1'b0};
        r_even = {r_sum[EXT_W-1:1], 1'b0};

        drop = (l_even >= $signed(EXT_W'(BUFFER_WIDTH))) ||
               (r_even <= $signed(EXT_W'(0))) ||
               (b_ext <= $signed(EXT_W'(0))) ||
               (t_ext >= $signed(EXT_W'(BUFFER_HEIGHT)));

        clipped.left   = (l_even < $signed(EXT_W'(0))) ? '0 : l_even[LEFT_W-1:0];
        clipped.right  = (r_even > $signed(EXT_W'(BUFFER_WIDTH))) ?
                         COORD_W'(BUFFER_WIDTH) : r_even[COORD_W-1:0];
        clipped.top    = (t_ext < $signed(EXT_W'(0))) ? '0 : t_ext[COORD_W-1:0];
        clipped.bottom = (b_ext > $signed(EXT_W'(BUFFER_HEIGHT))) ?
                         COORD_W'(BUFFER_HEIGHT) : b_ext[COORD_W-1:0];
    end

    // Bottom-half coordinates of the head region.
    assign top_rebased = head.top - COORD_W'(HALF_HEIGHT);
    assign bot_rebased = {1'b0, head.bottom} - (COORD_W+1)'(HALF_HEIGHT);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pending_next = pending_reg;
        half_next    = half_reg;
        walk_next    = walk_reg;
        rect_next    = rect_reg;

        strobe_next  = 1'b0;
        screen_next  = screen_reg;
        left_next    = left_reg;
        top_next     = top_reg;
        right_next   = right_reg;
        bottom_next  = bottom_reg;
        last_next    = 1'b0;

        ctrl.op      = CELL_HOLD;
        ctrl.rect    = rect_reg;
        launch       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_INVALIDATE:
                        begin
                            rect_next = clipped;
                            walk_next = '0;
                            if (!drop)
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        MODE_REQUEST:
                        begin
                            pending_next = 1'b1;
                        end
                        MODE_SERVICE:
                        begin
                            // a service without a pending request is a no-op
                            if (pending_reg)
                            begin
                                pending_next = 1'b0;
                                half_next    = 1'b0;
                                if (count_reg != '0)
                                begin
                                    state_next = ST_FLUSH;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // inject the token into the newest cell on the first step
                launch.active = (walk_reg == '0);
                walk_next     = walk_reg + WALK_W'(1);
                if (walk_reg == WALK_W'(MAX_REGIONS - 1))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
                if (!probe_q[MAX_REGIONS-1].found)
                begin
                    ctrl.op = CELL_SHIFT_UP;
                    if (count_reg >= COUNT_W'(MAX_REGIONS))
                    begin
                        // table full: collapse to one full-screen region
                        ctrl.rect  = FULL_SCREEN;
                        count_next = COUNT_W'(1);
                    end
                    else
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                strobe_next = 1'b1;
                left_next   = head.left;
                right_next  = head.right;
                if (half_reg)
                begin
                    // lower piece of a region that spans both halves
                    screen_next = 1'b1;
                    top_next    = '0;
                    bottom_next = bot_rebased[8:0];
                    half_next   = 1'b0;
                end
                else if (head.top < COORD_W'(HALF_HEIGHT))
                begin
                    screen_next = 1'b0;
                    top_next    = head.top[7:0];
                    if (head.bottom <= COORD_W'(HALF_HEIGHT))
                    begin
                        bottom_next = head.bottom[8:0];
                    end
                    else
                    begin
                        bottom_next = 9'(HALF_HEIGHT);
                        half_next   = 1'b1;
                    end
                end
                else
                begin
                    screen_next = 1'b1;
                    top_next    = top_rebased[7:0];
                    bottom_next = bot_rebased[8:0];
                end

                // advance to the next older region once this one is done
                if (!half_next)
                begin
                    ctrl.op    = CELL_SHIFT_DOWN;
                    count_next = count_reg - COUNT_W'(1);
                    if (count_reg == COUNT_W'(1))
                    begin
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pending_reg <= 1'b0;
            half_reg    <= 1'b0;
            walk_reg    <= '0;
            strobe_reg  <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
            half_reg    <= half_next;
            walk_reg    <= walk_next;
            strobe_reg  <= strobe_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rect_reg   <= rect_next;
        screen_reg <= screen_next;
        left_reg   <= left_next;
        top_reg    <= top_next;
        right_reg  <= right_next;
        bottom_reg <= bottom_next;
    end

    assign strobe     = strobe_reg;
    assign screen     = screen_reg;
    assign out_left   = left_reg;
    assign out_top    = top_reg;
    assign out_right  = right_reg;
    assign out_bottom = $signed(bottom_reg);
    assign last       = last_reg;

    // Cell 0 holds the newest region; older regions sit further down the chain.
    for (genvar i = 0; i < MAX_REGIONS; i++)
    begin : g_cell
        region_t up_src;
        region_t dn_src;
        probe_t  probe_src;

        if (i == 0)
        begin : g_head
            assign up_src    = ctrl.rect;
            assign probe_src = launch;
        end
        else
        begin : g_body
            assign up_src    = cell_q[i-1];
            assign probe_src = probe_q[i-1];
        end

        if (i == MAX_REGIONS - 1)
        begin : g_tail
            assign dn_src = cell_q[i];
        end
        else
        begin : g_link
            assign dn_src = cell_q[i+1];
        end

        assign in_use[i]    = (COUNT_W'(i) < count_reg);
        assign probe_act[i] = probe_q[i].active;

        drt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .in_use    (in_use[i]),
            .up_in     (up_src),
            .dn_in     (dn_src),
            .probe_in  (probe_src),
            .probe_out (probe_q[i]),
            .region    (cell_q[i])
        );
    end

    // The region count never exceeds the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_REGIONS))
        else $error("region count above table size");

    // At most one probe token travels the chain.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(probe_act))
        else $error("more than one probe token in the chain");

    // No token is left in the chain while idle.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (probe_act == '0))
        else $error("probe token alive while idle");

    // Results come only out of a flush.
    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg == ST_FLUSH))
        else $error("result strobe outside a flush");

    // The final result of a flush leaves the table empty.
    a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
        last_reg |-> (strobe_reg && (count_reg == '0)))
        else $error("last result with regions still stored");

endmodule

// File: hdl/drt_cell.sv
// One cell of the region chain: holds one region, merges the probe
// rectangle on a hit and hands its probe token and region to its neighbors.
// Depends on drt_pkg.
module drt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  drt_pkg::cell_ctrl_t ctrl,
    input  logic                in_use,
    input  drt_pkg::region_t    up_in,
    input  drt_pkg::region_t    dn_in,
    input  drt_pkg::probe_t     probe_in,
    output drt_pkg::probe_t     probe_out,
    output drt_pkg::region_t    region
);
    import drt_pkg::*;

    region_t region_reg;
    region_t region_next;
    region_t merged;
    probe_t  probe_reg;
    probe_t  probe_next;
    logic [COORD_W-1:0] g_left;
    logic [COORD_W-1:0] p_left;
    logic overlap;
    logic hit;

    always_comb
    begin
        g_left  = {{(COORD_W-LEFT_W){1'b0}}, region_reg.left};
        p_left  = {{(COORD_W-LEFT_W){1'b0}}, ctrl.rect.left};
        overlap = !((p_left > region_reg.right) || (ctrl.rect.right < g_left) ||
                    (ctrl.rect.top > region_reg.bottom) ||
                    (ctrl.rect.bottom < region_reg.top));
        hit = probe_in.active && !probe_in.found && in_use && overlap;

        // grow to the bounding box
        merged = region_reg;
        if (ctrl.rect.left < region_reg.left)
        begin
            merged.left = ctrl.rect.left;
        end
        if (ctrl.rect.right > region_reg.right)
        begin
            merged.right = ctrl.rect.right;
        end
        if (ctrl.rect.top < region_reg.top)
        begin
            merged.top = ctrl.rect.top;
        end
        if (ctrl.rect.bottom > region_reg.bottom)
        begin
            merged.bottom = ctrl.rect.bottom;
        end

        case (ctrl.op)
            CELL_HOLD:       region_next = hit ? merged : region_reg;
            CELL_SHIFT_UP:   region_next = up_in;
            CELL_SHIFT_DOWN: region_next = dn_in;
            default:         region_next = region_reg;
        endcase

        probe_next.active = probe_in.active;
        probe_next.found  = probe_in.found || hit;
    end

    always_ff @(posedge clk)
    begin
        region_reg <= region_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    assign probe_out = probe_reg;
    assign region    = region_reg;

endmodule
